FILE: design/nfpi_pkg.sv
// ----------------------------------------------------------------------------
// Negative film inversion package
// Shared widths, constants, types and arithmetic helpers for the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nfpi_pkg;

   // Sample and fixed-point formats
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int RATIO_W     = SAMPLE_BITS + FRAC_BITS;
   localparam int OUT_W       = 25;
   localparam int LOG_W       = 23;
   localparam int EXP_W       = 28;
   localparam int VAL_W       = 26;

   // Pipeline geometry
   localparam int DIV_BITS    = 4;
   localparam int DIV_STAGES  = RATIO_W / DIV_BITS;
   localparam int NUM_STAGES  = DIV_STAGES + 11;

   // Parabolic correction factors, Q0.16
   localparam logic [15:0] LOG_BODGE = 16'd22715;
   localparam logic [15:0] POW_BODGE = 16'd22263;

   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

   // Register indexes of the control port
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RED_FLOOR    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GREEN_FLOOR  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLUE_FLOOR   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIGHT_OFFSET = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GREEN_GAMMA  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLUE_GAMMA   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIX_ENABLE   = 3'd6;

   // Partial state of the restoring divider
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] rem;
      logic [RATIO_W-1:0]     num;
      logic [RATIO_W-1:0]     q;
   } div_type;

   // Several quotient bits of a restoring division, msb first
   function automatic div_type div_step(div_type d, logic [SAMPLE_BITS-1:0] dvsr);
      div_type r;
      logic [SAMPLE_BITS:0] t;
      r = d;
      for (int j = 0; j < DIV_BITS; j++) begin
         t     = {r.rem, r.num[RATIO_W-1]};
         r.num = {r.num[RATIO_W-2:0], 1'b0};
         if (t >= {1'b0, dvsr}) begin
            r.rem = SAMPLE_BITS'(t - {1'b0, dvsr});
            r.q   = {r.q[RATIO_W-2:0], 1'b1};
         end else begin
            r.rem = t[SAMPLE_BITS-1:0];
            r.q   = {r.q[RATIO_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Leading zero count of a 16-bit word (zero word gives 0)
   function automatic logic [3:0] lead_zero16(logic [15:0] v);
      logic [3:0] lz;
      lz = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) begin
            lz = 4'(15 - i);
         end
      end
      return lz;
   endfunction

endpackage

`default_nettype wire

FILE: design/nfpi_chan.sv
// ----------------------------------------------------------------------------
// Negative film channel datapath
// Ratio floor/sample by pipelined division, optional power through log2 and
// exp2 approximations, light subtraction and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfpi_chan #(
   parameter bit USE_POW = 1'b1
) (
   input  wire logic                                 clock,
   input  wire logic [nfpi_pkg::NUM_STAGES-1:0]      en,
   input  wire logic [nfpi_pkg::SAMPLE_BITS-1:0]     sample,
   input  wire logic [nfpi_pkg::SAMPLE_BITS-1:0]     floor_val,
   input  wire logic [15:0]                          gamma,
   input  wire logic [15:0]                          light,
   input  wire logic                                 fix_en,
   output logic      [nfpi_pkg::OUT_W-1:0]           out_val,
   output logic                                      out_flag
);

   localparam int NS = nfpi_pkg::NUM_STAGES;
   localparam int DS = nfpi_pkg::DIV_STAGES;
   localparam int SB = nfpi_pkg::SAMPLE_BITS;
   localparam int RW = nfpi_pkg::RATIO_W;
   localparam int FB = nfpi_pkg::FRAC_BITS;
   localparam int VW = nfpi_pkg::VAL_W;
   localparam int EW = nfpi_pkg::EXP_W;
   localparam int LW = nfpi_pkg::LOG_W;
   localparam int OW = nfpi_pkg::OUT_W;

   // Sample rides along every stage up to the output select
   logic [SB-1:0] samp_ff [NS-1];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         samp_ff[0] <= sample;
      end
      for (int i = 1; i < NS - 1; i++) begin
         if (en[i]) begin
            samp_ff[i] <= samp_ff[i-1];
         end
      end
   end

   // Divider: a few quotient bits per stage
   nfpi_pkg::div_type div_ff [DS];

   for (genvar g = 0; g < DS; g++) begin : g_div
      nfpi_pkg::div_type div_in;
      if (g == 0) begin : g_first
         nfpi_pkg::div_type start;
         assign start  = {{SB{1'b0}}, floor_val, {FB{1'b0}}, {RW{1'b0}}};
         assign div_in = nfpi_pkg::div_step(start, sample);
      end else begin : g_rest
         assign div_in = nfpi_pkg::div_step(div_ff[g-1], samp_ff[g-1]);
      end
      always_ff @(posedge clock) begin
         if (en[g]) begin
            div_ff[g] <= div_in;
         end
      end
   end

   // Ratio rides along after the divider
   logic [RW-1:0] ratio_ff [DS:NS-2];

   always_ff @(posedge clock) begin
      if (en[DS]) begin
         ratio_ff[DS] <= div_ff[DS-1].q;
      end
      for (int i = DS + 1; i < NS - 1; i++) begin
         if (en[i]) begin
            ratio_ff[i] <= ratio_ff[i-1];
         end
      end
   end

   // log2, coarse normalize by half word
   logic [RW-1:0] n1_ff;
   logic          hi_ff;
   logic          hi_in;

   assign hi_in = |div_ff[DS-1].q[RW-1:RW/2];

   always_ff @(posedge clock) begin
      if (en[DS]) begin
         hi_ff <= hi_in;
         n1_ff <= hi_in ? div_ff[DS-1].q : {div_ff[DS-1].q[RW/2-1:0], {(RW/2){1'b0}}};
      end
   end

   // log2, fine normalize, mantissa and exponent
   logic [3:0]    lz_in;
   logic [RW-1:0] n2_in;
   logic [15:0]   m_ff;
   logic [4:0]    p_ff;

   assign lz_in = nfpi_pkg::lead_zero16(n1_ff[RW-1:RW/2]);
   assign n2_in = n1_ff << lz_in;

   always_ff @(posedge clock) begin
      if (en[DS+1]) begin
         m_ff <= n2_in[RW-2:RW-17];
         p_ff <= {hi_ff, 4'(4'd15 - lz_in)};
      end
   end

   // log2, mantissa square
   logic [15:0] m10_ff;
   logic [4:0]  p10_ff;
   logic [31:0] mm_ff;

   always_ff @(posedge clock) begin
      if (en[DS+2]) begin
         m10_ff <= m_ff;
         p10_ff <= p_ff;
         mm_ff  <= 32'(m_ff) * 32'(m_ff);
      end
   end

   // log2, parabolic correction
   logic [16:0] ld_in;
   logic [32:0] lprod_in;
   logic [15:0] m11_ff;
   logic [4:0]  p11_ff;
   logic [16:0] lcorr_ff;

   assign ld_in    = {1'b0, m10_ff} - {1'b0, mm_ff[31:16]};
   assign lprod_in = 33'(ld_in) * 33'(nfpi_pkg::LOG_BODGE);

   always_ff @(posedge clock) begin
      if (en[DS+3]) begin
         m11_ff   <= m10_ff;
         p11_ff   <= p10_ff;
         lcorr_ff <= lprod_in[32:16];
      end
   end

   // log2 assembled
   logic [5:0]    psub_in;
   logic [LW-1:0] log_in;
   logic [LW-1:0] log_ff;

   assign psub_in = {1'b0, p11_ff} - 6'd16;
   assign log_in  = {psub_in[5], psub_in, 16'b0} + {7'b0, m11_ff} + {6'b0, lcorr_ff};

   always_ff @(posedge clock) begin
      if (en[DS+4]) begin
         log_ff <= log_in;
      end
   end

   // Exponent times log2, floored to the fraction
   logic signed [39:0] gprod_in;
   logic [EW-1:0]      t_ff;

   assign gprod_in = 40'($signed({1'b0, gamma})) * 40'($signed(log_ff));

   always_ff @(posedge clock) begin
      if (en[DS+5]) begin
         t_ff <= gprod_in[EW+11:12];
      end
   end

   // exp2, fraction square
   logic [EW-1:0] t14_ff;
   logic [31:0]   yy_ff;

   always_ff @(posedge clock) begin
      if (en[DS+6]) begin
         t14_ff <= t_ff;
         yy_ff  <= 32'(t_ff[15:0]) * 32'(t_ff[15:0]);
      end
   end

   // exp2, parabolic correction
   logic [16:0]   ed_in;
   logic [32:0]   eprod_in;
   logic [EW-1:0] t15_ff;
   logic [16:0]   ecorr_ff;

   assign ed_in    = {1'b0, t14_ff[15:0]} - {1'b0, yy_ff[31:16]};
   assign eprod_in = 33'(ed_in) * 33'(nfpi_pkg::POW_BODGE);

   always_ff @(posedge clock) begin
      if (en[DS+7]) begin
         t15_ff   <= t14_ff;
         ecorr_ff <= eprod_in[32:16];
      end
   end

   // exp2, corrected exponent
   logic [EW-1:0] w_ff;

   always_ff @(posedge clock) begin
      if (en[DS+8]) begin
         w_ff <= t15_ff - EW'(ecorr_ff);
      end
   end

   // exp2, scale the mantissa by the integer part
   logic signed [EW-17:0] k_in;
   logic [16:0]           mant_in;
   logic [4:0]            nk_in;
   logic [VW-1:0]         pval_in;
   logic                  pbig_in;
   logic [VW-1:0]         pval_ff;
   logic                  pbig_ff;

   assign k_in    = $signed(w_ff[EW-1:16]);
   assign mant_in = {1'b1, w_ff[15:0]};
   assign nk_in   = 5'(-k_in);

   always_comb begin
      pval_in = '0;
      pbig_in = 1'b0;
      if (k_in > 12'sd8) begin
         pbig_in = 1'b1;
      end else if (k_in >= 12'sd0) begin
         pval_in = VW'(mant_in) << k_in[3:0];
      end else if (k_in >= -12'sd16) begin
         pval_in = VW'(mant_in >> nk_in);
      end
   end

   always_ff @(posedge clock) begin
      if (en[DS+9]) begin
         pval_ff <= pval_in;
         pbig_ff <= pbig_in;
      end
   end

   // Select, subtract light and saturate
   logic [VW-1:0]   val_in;
   logic            big_in;
   logic [VW:0]     diff_in;
   logic [OW-1:0]   out_in;
   logic            flag_in;
   logic [SB-1:0]   s_last;
   logic [RW-1:0]   r_last;

   assign s_last = samp_ff[NS-2];
   assign r_last = ratio_ff[NS-2];

   always_comb begin
      if (!USE_POW) begin
         val_in = {1'b0, r_last[VW-2:0]};
         big_in = |r_last[RW-1:VW-1];
      end else if (r_last == '0) begin
         val_in = (gamma == 16'd0) ? VW'(1 << FB) : '0;
         big_in = 1'b0;
      end else begin
         val_in = pval_ff;
         big_in = pbig_ff;
      end
      diff_in = {1'b0, val_in} - (VW+1)'(light);
      if (!fix_en) begin
         out_in  = OW'(s_last);
         flag_in = 1'b0;
      end else if (s_last == '0) begin
         out_in  = nfpi_pkg::OUT_MAX;
         flag_in = 1'b1;
      end else if (big_in || (!diff_in[VW] && (diff_in[VW-1] || diff_in[VW-2]))) begin
         out_in  = nfpi_pkg::OUT_MAX;
         flag_in = 1'b1;
      end else begin
         out_in  = diff_in[OW-1:0];
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         out_val  <= out_in;
         out_flag <= flag_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/negative_film_pixel_inversion.sv
// ----------------------------------------------------------------------------
// Negative film pixel inversion
// An accepted req beat passes through every stage register on its way to its rsp beat.
// Throughput: one pixel per cycle; each stage holds when the one after it is
// full and stalled, so bubbles close up under back pressure.
// Reset (synchronous): clears all stage valid bits and the control registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module negative_film_pixel_inversion (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [47:0]                        req_tdata,  // sample_red, sample_green, sample_blue
   // response stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [79:0]                             rsp_tdata,  // out_red, out_green, out_blue, pad
   output logic                                    rsp_tuser,  // range_flag
   // control registers
   input  wire logic                               csr_we,
   input  wire logic [nfpi_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [15:0]                        csr_wdata
);

   localparam int NS = nfpi_pkg::NUM_STAGES;
   localparam int OW = nfpi_pkg::OUT_W;
   localparam int SB = nfpi_pkg::SAMPLE_BITS;

   // Control registers
   logic [15:0] red_floor_ff, green_floor_ff, blue_floor_ff;
   logic [15:0] light_ff, green_gamma_ff, blue_gamma_ff;
   logic        fix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_floor_ff   <= '0;
         green_floor_ff <= '0;
         blue_floor_ff  <= '0;
         light_ff       <= '0;
         green_gamma_ff <= '0;
         blue_gamma_ff  <= '0;
         fix_ff         <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            nfpi_pkg::CSR_RED_FLOOR:    red_floor_ff   <= csr_wdata;
            nfpi_pkg::CSR_GREEN_FLOOR:  green_floor_ff <= csr_wdata;
            nfpi_pkg::CSR_BLUE_FLOOR:   blue_floor_ff  <= csr_wdata;
            nfpi_pkg::CSR_LIGHT_OFFSET: light_ff       <= csr_wdata;
            nfpi_pkg::CSR_GREEN_GAMMA:  green_gamma_ff <= csr_wdata;
            nfpi_pkg::CSR_BLUE_GAMMA:   blue_gamma_ff  <= csr_wdata;
            nfpi_pkg::CSR_FIX_ENABLE:   fix_ff         <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when it is empty or its successor moves
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NS-1];

   // Channel datapaths
   logic [OW-1:0] red_out, green_out, blue_out;
   logic          red_flag, green_flag, blue_flag;

   nfpi_chan #(.USE_POW(1'b0)) u_red (
      .clock     (clock),
      .en        (en),
      .sample    (req_tdata[SB-1:0]),
      .floor_val (red_floor_ff[SB-1:0]),
      .gamma     (16'd0),
      .light     (light_ff),
      .fix_en    (fix_ff),
      .out_val   (red_out),
      .out_flag  (red_flag)
   );

   nfpi_chan #(.USE_POW(1'b1)) u_green (
      .clock     (clock),
      .en        (en),
      .sample    (req_tdata[16+SB-1:16]),
      .floor_val (green_floor_ff[SB-1:0]),
      .gamma     (green_gamma_ff),
      .light     (light_ff),
      .fix_en    (fix_ff),
      .out_val   (green_out),
      .out_flag  (green_flag)
   );

   nfpi_chan #(.USE_POW(1'b1)) u_blue (
      .clock     (clock),
      .en        (en),
      .sample    (req_tdata[32+SB-1:32]),
      .floor_val (blue_floor_ff[SB-1:0]),
      .gamma     (blue_gamma_ff),
      .light     (light_ff),
      .fix_en    (fix_ff),
      .out_val   (blue_out),
      .out_flag  (blue_flag)
   );

   // Response beat
   assign rsp_tdata = {5'b0, blue_out, green_out, red_out};
   assign rsp_tuser = red_flag | green_flag | blue_flag;

endmodule

`default_nettype wire

FILE: test/negative_film_pixel_inversion_test.sv
// ----------------------------------------------------------------------------
// Negative film pixel inversion testbench
// Drives pixel beats under random back pressure and gaps, predicts each
// response in fixed point and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module negative_film_pixel_inversion_test;

   localparam int PIXEL_COUNT = 1700;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [24:0] red;
      logic [24:0] green;
      logic [24:0] blue;
      bit          flag;
   } inverted_pixel_type;

   // Predicts inverted pixels and holds them until their beat arrives
   class inversion_scoreboard;
      logic [15:0] red_floor, green_floor, blue_floor, light_offset;
      logic [15:0] green_gamma, blue_gamma;
      bit          fix_enable;
      inverted_pixel_type pending[$];

      function new();
         red_floor = 0; green_floor = 0; blue_floor = 0; light_offset = 0;
         green_gamma = 0; blue_gamma = 0; fix_enable = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            nfpi_pkg::CSR_RED_FLOOR:    red_floor = val;
            nfpi_pkg::CSR_GREEN_FLOOR:  green_floor = val;
            nfpi_pkg::CSR_BLUE_FLOOR:   blue_floor = val;
            nfpi_pkg::CSR_LIGHT_OFFSET: light_offset = val;
            nfpi_pkg::CSR_GREEN_GAMMA:  green_gamma = val;
            nfpi_pkg::CSR_BLUE_GAMMA:   blue_gamma = val;
            nfpi_pkg::CSR_FIX_ENABLE:   fix_enable = val[0];
            default: ;
         endcase
      endfunction

      // Parabolic log2 of a Q16.16 ratio, r > 0
      function longint log2_fix(longint unsigned r);
         int p;
         longint unsigned rest, m, corr;
         p = 63;
         while (p > 0 && r[p] == 1'b0) p--;
         rest = r - (64'd1 << p);
         m = (p >= 16) ? (rest >> (p - 16)) : (rest << (16 - p));
         corr = ((m - ((m * m) >> 16)) * 64'(nfpi_pkg::LOG_BODGE)) >> 16;
         return longint'(p - 16) * 65536 + longint'(m + corr);
      endfunction

      // Parabolic exp2 of a signed Q.16 exponent
      function longint unsigned exp2_fix(longint v);
         longint unsigned y, corr, mant;
         longint w, k;
         y = longint'(v) & 64'hFFFF;
         corr = ((y - ((y * y) >> 16)) * 64'(nfpi_pkg::POW_BODGE)) >> 16;
         w = v - longint'(corr);
         k = w >>> 16;
         mant = 64'd65536 + (w & 64'hFFFF);
         if (k > 30) return 64'd1 << 60;
         if (k >= 0) return mant << k;
         if (k <= -63) return 0;
         return mant >> (-k);
      endfunction

      function logic [24:0] invert(logic [15:0] s, logic [15:0] fl, logic [15:0] gamma,
                                   bit use_pow, inout bit flag);
         longint unsigned ratio, val;
         longint t, res;
         if (s == 0) begin
            flag = 1;
            return 25'h0FFFFFF;
         end
         ratio = (64'(fl) << 16) / 64'(s);
         if (!use_pow) val = ratio;
         else if (ratio == 0) val = (gamma == 0) ? 64'd65536 : 64'd0;
         else begin
            t = (longint'(gamma) * log2_fix(ratio)) >>> 12;
            val = exp2_fix(t);
         end
         res = longint'(val) - longint'(light_offset);
         if (res > 64'sd16777215) begin flag = 1; res = 16777215; end
         if (res < -64'sd16777216) begin flag = 1; res = -16777216; end
         return res[24:0];
      endfunction

      function void note_pixel(logic [47:0] d);
         inverted_pixel_type e;
         bit f;
         f = 0;
         if (!fix_enable) begin
            e.red = 25'(d[15:0]); e.green = 25'(d[31:16]); e.blue = 25'(d[47:32]);
         end else begin
            e.red   = invert(d[15:0], red_floor, 16'd0, 0, f);
            e.green = invert(d[31:16], green_floor, green_gamma, 1, f);
            e.blue  = invert(d[47:32], blue_floor, blue_gamma, 1, f);
         end
         e.flag = f;
         pending.push_back(e);
      endfunction

      // Empty string when the beat matches the oldest expectation
      function string check_pixel(logic [79:0] d, logic u);
         inverted_pixel_type e;
         string s;
         if (pending.size() == 0) return $sformatf("unexpected rsp beat %h", d);
         e = pending.pop_front();
         s = "";
         if (d[24:0] !== e.red)
            s = {s, $sformatf(" red %h/%h", d[24:0], e.red)};
         if (d[49:25] !== e.green)
            s = {s, $sformatf(" green %h/%h", d[49:25], e.green)};
         if (d[74:50] !== e.blue)
            s = {s, $sformatf(" blue %h/%h", d[74:50], e.blue)};
         if (u !== e.flag)
            s = {s, $sformatf(" flag %b/%b", u, e.flag)};
         return (s == "") ? "" : {"mismatch got/exp:", s};
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = 0;   // sample_red, sample_green, sample_blue
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;       // out_red, out_green, out_blue, pad
   logic        rsp_tuser;       // range_flag
   logic        csr_we = 0;
   logic [2:0]  csr_addr = 0;
   logic [15:0] csr_wdata = 0;

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   int errors = 0;
   int pixels_sent = 0;
   int pixels_checked = 0;
   inversion_scoreboard board = new();

   negative_film_pixel_inversion uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #2000000;
      $display("timeout with %0d pixels pending", board.pending.size());
      $display("negative_film_pixel_inversion verification failed");
      $finish;
   end

   task automatic report(string msg);
      errors++;
      $display("%t %s", $realtime, msg);
   endtask

   // Sink side back pressure
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   // Beat monitor
   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            pixels_checked++;
            msg = board.check_pixel(rsp_tdata, rsp_tuser);
            if (msg != "") report(msg);
         end
      end
   end

   task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {b, g, r};
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      board.set_reg(idx, val);
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic load_config(logic [15:0] rf, logic [15:0] gf, logic [15:0] bf,
                              logic [15:0] lo, logic [15:0] gg, logic [15:0] bg,
                              bit fix);
      drain();
      write_reg(nfpi_pkg::CSR_RED_FLOOR, rf);
      write_reg(nfpi_pkg::CSR_GREEN_FLOOR, gf);
      write_reg(nfpi_pkg::CSR_BLUE_FLOOR, bf);
      write_reg(nfpi_pkg::CSR_LIGHT_OFFSET, lo);
      write_reg(nfpi_pkg::CSR_GREEN_GAMMA, gg);
      write_reg(nfpi_pkg::CSR_BLUE_GAMMA, bg);
      // upper bits of the enable word must be dropped
      write_reg(nfpi_pkg::CSR_FIX_ENABLE, {15'($urandom_range(32767)), fix});
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'($urandom_range(3));
         2:       return 16'hFFFF;
         3:       return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_gamma();
      case ($urandom_range(4))
         0:       return 16'd0;
         1:       return 16'($urandom_range(8192));
         2:       return 16'h1000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int per_phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: pass through extremes, then inversion corner cases
      send_pixel(16'h0000, 16'hFFFF, 16'h8000);
      send_pixel(16'hFFFF, 16'h0000, 16'h0001);
      load_config(16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'h1000, 16'h2000, 1);
      write_reg(3'd7, 16'hFFFF);   // unused index, no effect
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'h0001, 16'h0001, 16'h0001);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h8000, 16'h4000, 16'h2000);
      send_pixel(16'h1234, 16'h0003, 16'h7FFF);
      load_config(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h3000, 1);
      send_pixel(16'h0001, 16'h0001, 16'h0001);
      send_pixel(16'hFFFF, 16'h0005, 16'h0000);
      load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1);
      send_pixel(16'h0001, 16'h0001, 16'h0001);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h0002, 16'h8000, 16'hF000);
      load_config(16'hFFFF, 16'h0100, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0400, 1);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h0100, 16'hFFFF, 16'h0001);

      // Random phases, each with its own setting and one of three idle patterns
      per_phase = PIXEL_COUNT / 8;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7)
            load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        pick_gamma(), pick_gamma(), 0);
         else
            load_config(16'($urandom), 16'($urandom), 16'($urandom),
                        ($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(255))),
                        pick_gamma(), pick_gamma(), 1);
         tx_idle_pct = (ph < 3) ? 6 : (ph < 6) ? 55 : 0;
         rx_idle_pct = (ph < 3) ? 55 : (ph < 6) ? 6 : 0;
         for (int i = 0; i < per_phase; i++) begin
            // hold off once per phase until the pipe is empty
            if (i == per_phase / 2) begin
               @(negedge clock);
               req_tvalid <= 0;
               while (board.pending.size() != 0) @(posedge clock);
            end
            send_pixel(pick_sample(), pick_sample(), pick_sample());
         end
      end

      drain();
      $display("sent %0d pixels over 12 settings, %0d responses checked", pixels_sent,
               pixels_checked);
      $display("covered pass through, zero samples and floors, saturation, gap and stall mix");
      if (errors == 0)
         $display("negative_film_pixel_inversion verification clean");
      else
         $display("negative_film_pixel_inversion verification failed");
      $finish;
   end

endmodule
